/* design/hbs_pkg.sv */
// Shared widths and constants for the histogram bar scaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package hbs_pkg;

    localparam int SAMPLE_W = 31;
    localparam int COUNT_W  = 32;
    localparam int FS_W     = 8;
    localparam int IDX_W    = 7;
    localparam int QUOT_W   = 8;
    localparam int DVD_W    = COUNT_W + FS_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FS_W-1:0]    FS_RESET  = 8'd50;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

/* design/histogram_bar_scaler.sv */
// Histogram engine with scaled bar lengths. Counters live in a one-port-write,
// one-port-read synchronous memory of NUM_BINS 32-bit words; the running
// maximum and the full-scale register sit in flops. Items are handled one at
// a time. A count transfer runs through the reduction of the sample modulo
// NUM_BINS (reciprocal multiply, then one correction), a memory read, the
// saturating increment with write-back, and the load of the output register.
// A query of an existing bin runs through the memory read, one 32x8 multiply
// feeding the divider, the restoring divider that forms
// count * full_scale / max, the hand-over of the quotient and the output load.
// With the maximum or the full scale at zero the divider is skipped; a query
// of a bin at or beyond NUM_BINS skips the memory read as well. A consumer
// stall adds its length while a result waits. After reset the counter memory
// is swept to zero, one word a cycle; o_in_ready stays low until the sweep
// ends (configuration writes are taken throughout). A finished result waits
// in the output register, so the next item is taken while the previous
// result is still held for the consumer.
// The full-scale register may be written only while the block is idle.
`default_nettype none

module histogram_bar_scaler
    import hbs_pkg::*;
#(
    parameter int NUM_BINS = 100
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_action,
    input  wire logic [SAMPLE_W-1:0] i_sample_value,
    input  wire logic [IDX_W-1:0]    i_query_bin,
    // output channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [IDX_W-1:0]         o_bin_index,
    output logic [COUNT_W-1:0]       o_bin_count,
    output logic [FS_W-1:0]          o_bar_length,
    // configuration
    input  wire logic                i_cfg_wr_en,
    input  wire logic [FS_W-1:0]     i_cfg_wr_data
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // zeroing sweep after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // ready for a transfer
    localparam logic [2:0] S_MOD   = 3'd2;  // waiting for the bin reduction
    localparam logic [2:0] S_RMW   = 3'd3;  // read data valid, modify/write
    localparam logic [2:0] S_DIV   = 3'd4;  // waiting for the bar divider
    localparam logic [2:0] S_DONE  = 3'd5;  // result ready for output register

    logic [2:0]         r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [FS_W-1:0]    r_fs;
    logic [COUNT_W-1:0] r_largest;
    logic               r_action;
    logic [AW-1:0]      r_addr;

    // result staging and output register
    logic [IDX_W-1:0]   r_res_bin;
    logic [COUNT_W-1:0] r_res_count;
    logic [FS_W-1:0]    r_res_bar;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_bin;
    logic [COUNT_W-1:0] r_out_count;
    logic [FS_W-1:0]    r_out_bar;

    // counter memory
    logic [COUNT_W-1:0] r_mem [NUM_BINS];
    logic [COUNT_W-1:0] r_rd_data;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    logic               in_xfer;
    logic               q_in_range;
    logic               mod_start;
    logic               mod_done;
    logic [AW-1:0]      mod_bin;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;
    logic [DVD_W-1:0]   bar_prod;
    logic [COUNT_W-1:0] n_count;
    logic               load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign q_in_range = (32'(i_query_bin) < 32'(NUM_BINS));
    assign mod_start  = in_xfer && (i_action == ACT_COUNT);

    // saturating increment; the maximum saturates along with it
    assign n_count  = (r_rd_data == COUNT_MAX) ? r_rd_data : (r_rd_data + 1'b1);
    assign bar_prod = DVD_W'(r_rd_data) * DVD_W'(r_fs);

    // divide only when it can give a non-zero bar
    assign div_start = (r_state == S_RMW) && (r_action == ACT_QUERY)
                    && (r_largest != '0) && (r_fs != '0);

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // memory port steering
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        if (in_xfer && (i_action == ACT_QUERY) && q_in_range) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(i_query_bin);
        end else if ((r_state == S_MOD) && mod_done) begin
            mem_re    = 1'b1;
            mem_raddr = mod_bin;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = n_count;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if ((r_state == S_RMW) && (r_action == ACT_COUNT)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    hbs_bin_reduce #(
        .NUM_BINS (NUM_BINS)
    ) u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_sample (i_sample_value),
        .o_done   (mod_done),
        .o_bin    (mod_bin)
    );

    hbs_bar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (bar_prod),
        .i_divisor  (r_largest),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_fs        <= FS_RESET;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fs <= i_cfg_wr_data;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_action == ACT_COUNT) begin
                            r_state <= S_MOD;
                        end else if (q_in_range) begin
                            r_state <= S_RMW;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (r_action == ACT_COUNT) begin
                        if (n_count > r_largest) begin
                            r_largest <= n_count;
                        end
                        r_state <= S_DONE;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item payload and result staging
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action  <= i_action;
            r_addr    <= AW'(i_query_bin);
            r_res_bin <= i_query_bin;
            r_res_count <= '0;
            r_res_bar <= '0;
        end
        if ((r_state == S_MOD) && mod_done) begin
            r_addr    <= mod_bin;
            r_res_bin <= IDX_W'(mod_bin);
        end
        if (r_state == S_RMW) begin
            r_res_count <= (r_action == ACT_COUNT) ? n_count : r_rd_data;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_res_bar <= div_quot;
        end
        if (load_out) begin
            r_out_bin   <= r_res_bin;
            r_out_count <= r_res_count;
            r_out_bar   <= r_res_bar;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_out_bin;
    assign o_bin_count  = r_out_count;
    assign o_bar_length = r_out_bar;

endmodule

`default_nettype wire

/* design/hbs_bin_reduce.sv */
// Bin reduction: sample modulo the bin count by reciprocal multiplication, then one correction.
// Depends on hbs_pkg.
`default_nettype none

module hbs_bin_reduce
    import hbs_pkg::*;
#(
    parameter int NUM_BINS = 100
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [SAMPLE_W-1:0]         i_sample,
    output logic                             o_done,
    output logic [$clog2(NUM_BINS)-1:0]      o_bin
);

    localparam int AW    = $clog2(NUM_BINS);
    localparam int RW    = AW + 1;
    localparam int SHIFT = SAMPLE_W + AW;
    localparam int PW    = SAMPLE_W + 32;
    // floor(2^SHIFT / NUM_BINS): the quotient estimate is exact or one short
    localparam logic [31:0]   RECIP   = 32'((64'd1 << SHIFT) / 64'(NUM_BINS));
    localparam logic [RW-1:0] MODULUS = RW'(NUM_BINS);

    logic                r_busy;
    logic                r_done;
    logic [PW-1:0]       r_prod;
    logic [RW-1:0]       r_low;
    logic [RW-1:0]       r_rem;
    logic [RW-1:0]       n_qlow;
    logic [RW-1:0]       n_trial;
    logic [RW-1:0]       n_rem;

    // remainder lies below twice the modulus, so only the low RW bits matter
    always_comb begin
        n_qlow  = r_prod[SHIFT +: RW];
        n_trial = r_low - RW'(n_qlow * MODULUS);
        n_rem   = (n_trial >= MODULUS) ? (n_trial - MODULUS) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_sample) * PW'(RECIP);
            r_low  <= i_sample[RW-1:0];
        end
        if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_bin  = AW'(r_rem);

endmodule

`default_nettype wire

/* design/hbs_bar_div.sv */
// Restoring divider for the bar length, one quotient bit per cycle.
// Depends on hbs_pkg. Quotient must fit in QUOT_W bits (count <= maximum).
`default_nettype none

module hbs_bar_div
    import hbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [COUNT_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [QUOT_W-1:0]       o_quot
);

    localparam int CNW = $clog2(QUOT_W);
    localparam logic [CNW-1:0] LAST_STEP = CNW'(QUOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNW-1:0]    r_cnt;
    logic [DVD_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvs;
    logic [QUOT_W-1:0] r_quot;
    logic              n_ge;

    assign n_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend;
                r_dvs  <= DVD_W'(i_divisor) << (QUOT_W - 1);
                r_quot <= '0;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_dvs  <= r_dvs >> 1;
                r_quot <= {r_quot[QUOT_W-2:0], n_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for histogram_bar_scaler: directed table, then random transfers.
// Depends on hbs_pkg and histogram_bar_scaler; it carries its own histogram predictor.
`timescale 1ns / 1ps

module tb_top;
    import hbs_pkg::*;

    localparam int NUM_BINS   = 100;
    localparam int PHASE_LEN  = 250;
    localparam int NUM_PHASES = 6;
    // Longest item is a dividing query, so this settles the tail.
    localparam int DRAIN_CYCLES = 60;

    // One result as the block reports it
    typedef struct packed {
        logic [IDX_W-1:0]   bin;
        logic [COUNT_W-1:0] count;
        logic [FS_W-1:0]    bar;
    } bin_report_t;

    // Directed row: stimulus plus an optional hand-written answer
    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    qbin;
        logic                typed;
        bin_report_t         want;
    } dir_row_t;

    localparam int DIR_ROWS = 21;

    // Hand answers assume full scale at its reset value of 50.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty histogram: counts and bars are all zero
        '{ACT_QUERY, 31'd0,          7'd0,   1'b1, '{7'd0,   32'd0, 8'd0}},
        '{ACT_QUERY, 31'h7FFF_FFFF,  7'd99,  1'b1, '{7'd99,  32'd0, 8'd0}},
        // bin beyond the table echoes its number with zeros
        '{ACT_QUERY, 31'd0,          7'd127, 1'b1, '{7'd127, 32'd0, 8'd0}},
        '{ACT_COUNT, 31'd0,          7'd127, 1'b1, '{7'd0,   32'd1, 8'd0}},
        '{ACT_COUNT, 31'h7FFF_FFFF,  7'd0,   1'b1, '{7'd47,  32'd1, 8'd0}},
        '{ACT_COUNT, 31'd99,         7'd0,   1'b1, '{7'd99,  32'd1, 8'd0}},
        '{ACT_COUNT, 31'd100,        7'd0,   1'b1, '{7'd0,   32'd2, 8'd0}},
        // the tallest bin gets the full scale
        '{ACT_QUERY, 31'd0,          7'd0,   1'b1, '{7'd0,   32'd2, 8'd50}},
        '{ACT_QUERY, 31'd0,          7'd47,  1'b1, '{7'd47,  32'd1, 8'd25}},
        '{ACT_QUERY, 31'd0,          7'd100, 1'b1, '{7'd100, 32'd0, 8'd0}},
        '{ACT_COUNT, 31'd2147483600, 7'd0,   1'b1, '{7'd0,   32'd3, 8'd0}},
        '{ACT_QUERY, 31'd0,          7'd99,  1'b1, '{7'd99,  32'd1, 8'd16}},
        '{ACT_QUERY, 31'd0,          7'd50,  1'b1, '{7'd50,  32'd0, 8'd0}},
        // the rest go through the predictor
        '{ACT_COUNT, 31'h5555_5555,  7'h2A,  1'b0, '0},
        '{ACT_COUNT, 31'h2AAA_AAAA,  7'h55,  1'b0, '0},
        '{ACT_QUERY, 31'h2AAA_AAAA,  7'h55,  1'b0, '0},
        '{ACT_QUERY, 31'h5555_5555,  7'h2A,  1'b0, '0},
        '{ACT_QUERY, 31'd0,          7'd65,  1'b0, '0},
        '{ACT_QUERY, 31'd0,          7'd82,  1'b0, '0},
        '{ACT_COUNT, 31'd0,          7'h7F,  1'b0, '0},
        '{ACT_QUERY, 31'h7FFF_FFFF,  7'd0,   1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_action = ACT_COUNT;
    logic [SAMPLE_W-1:0] i_sample_value = '0;
    logic [IDX_W-1:0]    i_query_bin = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [IDX_W-1:0]    o_bin_index;
    logic [COUNT_W-1:0]  o_bin_count;
    logic [FS_W-1:0]     o_bar_length;
    logic                i_cfg_wr_en = 1'b0;
    logic [FS_W-1:0]     i_cfg_wr_data = '0;

    // Predictor state: its own copy of the counters, the peak and the scale
    logic [COUNT_W-1:0] tally [NUM_BINS];
    logic [COUNT_W-1:0] peak_count;
    logic [FS_W-1:0]    full_scale;

    bin_report_t pending_reports [$];

    int unsigned mismatches = 0;
    int unsigned n_counts = 0;
    int unsigned n_queries = 0;
    int unsigned n_results = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;   // stretch with no idling on either side

    int unsigned hot_bins [5] = '{0, 1, 42, 57, 99};

    histogram_bar_scaler #(
        .NUM_BINS(NUM_BINS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_sample_value (i_sample_value),
        .i_query_bin    (i_query_bin),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bin_index    (o_bin_index),
        .o_bin_count    (o_bin_count),
        .o_bar_length   (o_bar_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Histogram predictor: applies one item to the local copy and returns
    // the result the block owes for it. Counts saturate, and the peak
    // follows the counter that was just bumped.
    function automatic bin_report_t histogram_step(logic action,
                                                   logic [SAMPLE_W-1:0] sample,
                                                   logic [IDX_W-1:0] qbin);
        bin_report_t        rep;
        int unsigned        bin;
        logic [COUNT_W-1:0] c;
        logic [63:0]        prod;
        rep = '0;
        if (action == ACT_COUNT) begin
            bin = sample % NUM_BINS;
            c = tally[bin];
            if (c != COUNT_MAX)
                c = c + 1'b1;
            tally[bin] = c;
            if (c > peak_count)
                peak_count = c;
            rep.bin   = bin[IDX_W-1:0];
            rep.count = c;
        end else begin
            rep.bin = qbin;
            if (qbin < NUM_BINS) begin
                c = tally[qbin];
                rep.count = c;
                if (peak_count != 0) begin
                    prod = 64'(c) * 64'(full_scale);
                    rep.bar = FS_W'(prod / 64'(peak_count));
                end
            end
        end
        return rep;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        $display("error at %0t: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    // Random gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item and hold it until the input transfer happens; the
    // expectation is queued at the accepting edge. typed rows take the
    // hand-written answer but still run the predictor to keep its state.
    task automatic send_item(logic action, logic [SAMPLE_W-1:0] sample,
                             logic [IDX_W-1:0] qbin, logic typed, bin_report_t want);
        bin_report_t rep;
        int unsigned gap;
        i_in_valid     <= 1'b1;
        i_action       <= action;
        i_sample_value <= sample;
        i_query_bin    <= qbin;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        rep = histogram_step(action, sample, qbin);
        pending_reports.push_back(typed ? want : rep);
        if (action == ACT_COUNT)
            n_counts++;
        else
            n_queries++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Register writes only happen once every result is home.
    task automatic write_full_scale(logic [FS_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        full_scale = value;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // Output side: check each result transfer, then pick the next ready.
    always @(posedge i_clk) begin
        bin_report_t want;
        int unsigned r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result, bin", 64'd0, 64'(o_bin_index));
            end else begin
                want = pending_reports.pop_front();
                if (o_bin_index !== want.bin)
                    report_mismatch("bin_index", 64'(want.bin), 64'(o_bin_index));
                if (o_bin_count !== want.count)
                    report_mismatch("bin_count", 64'(want.count), 64'(o_bin_count));
                if (o_bar_length !== want.bar)
                    report_mismatch("bar_length", 64'(want.bar), 64'(o_bar_length));
            end
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 24)
                    stall_left = $urandom_range(10, 40);
            end
        end
    end

    // Main sequence: reset, directed table, then random phases over several
    // full-scale settings, extremes included.
    initial begin
        logic [FS_W-1:0]     phase_scale [NUM_PHASES];
        logic                action;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    qbin;
        int unsigned         r;
        for (int b = 0; b < NUM_BINS; b++)
            tally[b] = '0;
        peak_count = '0;
        full_scale = FS_RESET;
        phase_scale = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 254)), 8'd128,
                        8'($urandom_range(1, 255))};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset value of full scale
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].action, DIR_TABLE[i].sample, DIR_TABLE[i].qbin,
                      DIR_TABLE[i].typed, DIR_TABLE[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_full_scale(phase_scale[p]);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 40 == 0)
                    calm = ($urandom_range(0, 5) == 0);
                r = $urandom_range(0, 99);
                // ignored fields still get random content
                sample = SAMPLE_W'($urandom);
                qbin   = IDX_W'($urandom_range(0, 127));
                if (r < 60) begin
                    action = ACT_COUNT;
                    // half the samples land in a few hot bins so the peak
                    // and the bar lengths spread out
                    if ($urandom_range(0, 1) == 1)
                        sample = SAMPLE_W'($urandom_range(0, 21474835) * 100
                                           + hot_bins[$urandom_range(0, 4)]);
                end else begin
                    action = ACT_QUERY;
                    r = $urandom_range(0, 99);
                    if (r < 12)
                        qbin = IDX_W'($urandom_range(NUM_BINS, 127));
                    else if (r < 55)
                        qbin = IDX_W'(hot_bins[$urandom_range(0, 4)]);
                    else
                        qbin = IDX_W'($urandom_range(0, NUM_BINS - 1));
                end
                send_item(action, sample, qbin, 1'b0, '0);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d count and %0d query transfers, %0d results checked,",
                 n_counts, n_queries, n_results);
        $display("over %0d full-scale settings; tallest bin reached %0d.",
                 n_cfg_writes + 1, peak_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
